// File: hw/rtl/jpsi_pkg.sv
`timescale 1ns / 1ps
// Package for the interpolated joint PD servo: sizes, payload structs,
// datapath command and status structs, saturation helpers. No dependencies.
package jpsi_pkg;

   localparam int JOINTS     = 32;
   localparam int JOINT_AW   = (JOINTS > 1) ? $clog2(JOINTS) : 1;
   localparam int INVP_W     = 16;
   localparam int STEPS_W    = 11;
   localparam int CSR_DATA_W = 16;
   localparam int CSR_IDX_W  = 1;
   localparam int DIV_BITS   = 33;
   localparam int DIV_CNT_W  = $clog2(DIV_BITS + 1);
   localparam int MUL_A_W    = 33;
   localparam int MUL_B_W    = 16;
   localparam int PROD_W     = MUL_A_W + MUL_B_W;
   localparam int ACC_W      = PROD_W + 1;
   localparam int HIST_W     = 64;

   localparam logic [INVP_W-1:0]  INVP_RESET  = INVP_W'(200);
   localparam logic [STEPS_W-1:0] STEPS_RESET = STEPS_W'(1);

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_INVERSE_PERIOD = 1'b0,
      CSR_INTERP_STEPS   = 1'b1
   } csr_index_type;

   typedef enum logic [2:0] {
      OP_GAP = 3'd0,
      OP_DQ  = 3'd1,
      OP_DR  = 3'd2,
      OP_PE  = 3'd3,
      OP_DE  = 3'd4
   } op_sel_type;

   typedef enum logic [2:0] {
      GS_IP   = 3'd0,
      GS_P_LO = 3'd1,
      GS_P_HI = 3'd2,
      GS_D_LO = 3'd3,
      GS_D_HI = 3'd4
   } gain_sel_type;

   typedef struct packed {
      logic [4:0]         joint_index;
      logic               last_joint;
      logic               new_reference;
      logic signed [31:0] measured_angle;
      logic signed [31:0] target_angle;
      logic signed [31:0] reference_torque;
      logic               torque_mode;
      logic [30:0]        p_gain;
      logic [30:0]        d_gain;
      logic [30:0]        torque_limit;
   } req_type;

   typedef struct packed {
      logic [4:0]         out_joint;
      logic signed [31:0] drive_torque;
      logic               clamped;
   } rsp_type;

   typedef struct packed {
      logic         load;
      logic         hist_load;
      logic         op_load;
      op_sel_type   op_sel;
      logic         div_start;
      logic         div_step;
      logic         ref_load;
      logic         mul;
      gain_sel_type gain_sel;
      logic         dq_load;
      logic         dr_load;
      logic         acc_set;
      logic         acc_add;
      logic         pterm_load;
      logic         dterm_load;
      logic         sum_load;
      logic         out_load;
   } dp_cmd_type;

   typedef struct packed {
      logic div_last;
   } dp_status_type;

   // magnitude with sign -> saturated signed 32 bit
   function automatic logic signed [31:0] sat_mag(input logic [ACC_W-1:0] mag,
                                                  input logic neg);
      logic signed [31:0] res;
      if (!neg) begin
         res = (mag > ACC_W'(64'h7FFF_FFFF)) ? 32'sh7FFF_FFFF : $signed(mag[31:0]);
      end else begin
         res = (mag >= ACC_W'(64'h8000_0000)) ? $signed(32'h8000_0000)
                                               : -$signed(mag[31:0]);
      end
      return res;
   endfunction

   function automatic logic signed [31:0] sat_wide(input logic signed [33:0] v);
      logic signed [31:0] res;
      if (v > 34'sh0_7FFF_FFFF) begin
         res = 32'sh7FFF_FFFF;
      end else if (v < -34'sh0_8000_0000) begin
         res = $signed(32'h8000_0000);
      end else begin
         res = v[31:0];
      end
      return res;
   endfunction

endpackage

// File: hw/rtl/jpsi_ram.sv
`timescale 1ns / 1ps
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module jpsi_ram #(
   parameter int WIDTH = 64,
   parameter int DEPTH = 32
) (
   input  logic                                      clock,
   input  logic                                      wr_en,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
   input  logic [WIDTH-1:0]                          wr_data,
   input  logic                                      rd_en,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr,
   output logic [WIDTH-1:0]                          rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// File: hw/rtl/jpsi_ctrl.sv
`timescale 1ns / 1ps
// Sequencer for the joint servo: steps the datapath through fetch, divide,
// multiply and output phases. Depends on jpsi_pkg.
module jpsi_ctrl (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   output logic                   req_ready,
   output logic                   rsp_valid,
   input  logic                   rsp_ready,
   output jpsi_pkg::dp_cmd_type    cmd,
   input  jpsi_pkg::dp_status_type status
);
   import jpsi_pkg::*;

   typedef enum logic [16:0] {
      S_IDLE     = 17'h00001,
      S_FETCH    = 17'h00002,
      S_GAP      = 17'h00004,
      S_DIVSTART = 17'h00008,
      S_DIV      = 17'h00010,
      S_REF      = 17'h00020,
      S_MDQ      = 17'h00040,
      S_MDR      = 17'h00080,
      S_MPL      = 17'h00100,
      S_MPH      = 17'h00200,
      S_PACC     = 17'h00400,
      S_MDL      = 17'h00800,
      S_MDH      = 17'h01000,
      S_DACC     = 17'h02000,
      S_TERM     = 17'h04000,
      S_SUM      = 17'h08000,
      S_OUT      = 17'h10000
   } state_type;

   state_type state_ff, state_in;
   logic      rsp_valid_ff, rsp_valid_in;
   logic      out_free;

   assign req_ready = (state_ff == S_IDLE);
   assign rsp_valid = rsp_valid_ff;
   assign out_free  = !rsp_valid_ff || rsp_ready;

   always_comb begin
      cmd      = '0;
      state_in = state_ff;
      case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               cmd.load = 1'b1;
               state_in = S_FETCH;
            end
         end
         S_FETCH: begin
            cmd.hist_load = 1'b1;
            state_in      = S_GAP;
         end
         S_GAP: begin
            cmd.op_load = 1'b1;
            cmd.op_sel  = OP_GAP;
            state_in    = S_DIVSTART;
         end
         S_DIVSTART: begin
            cmd.div_start = 1'b1;
            state_in      = S_DIV;
         end
         S_DIV: begin
            cmd.div_step = 1'b1;
            if (status.div_last) begin
               state_in = S_REF;
            end
         end
         S_REF: begin
            cmd.ref_load = 1'b1;
            cmd.op_load  = 1'b1;
            cmd.op_sel   = OP_DQ;
            state_in     = S_MDQ;
         end
         S_MDQ: begin
            cmd.mul      = 1'b1;
            cmd.gain_sel = GS_IP;
            cmd.op_load  = 1'b1;
            cmd.op_sel   = OP_DR;
            state_in     = S_MDR;
         end
         S_MDR: begin
            cmd.mul      = 1'b1;
            cmd.gain_sel = GS_IP;
            cmd.dq_load  = 1'b1;
            cmd.op_load  = 1'b1;
            cmd.op_sel   = OP_PE;
            state_in     = S_MPL;
         end
         S_MPL: begin
            cmd.mul      = 1'b1;
            cmd.gain_sel = GS_P_LO;
            cmd.dr_load  = 1'b1;
            state_in     = S_MPH;
         end
         S_MPH: begin
            cmd.mul      = 1'b1;
            cmd.gain_sel = GS_P_HI;
            cmd.acc_set  = 1'b1;
            state_in     = S_PACC;
         end
         S_PACC: begin
            cmd.acc_add = 1'b1;
            cmd.op_load = 1'b1;
            cmd.op_sel  = OP_DE;
            state_in    = S_MDL;
         end
         S_MDL: begin
            cmd.mul        = 1'b1;
            cmd.gain_sel   = GS_D_LO;
            cmd.pterm_load = 1'b1;
            state_in       = S_MDH;
         end
         S_MDH: begin
            cmd.mul      = 1'b1;
            cmd.gain_sel = GS_D_HI;
            cmd.acc_set  = 1'b1;
            state_in     = S_DACC;
         end
         S_DACC: begin
            cmd.acc_add = 1'b1;
            state_in    = S_TERM;
         end
         S_TERM: begin
            cmd.dterm_load = 1'b1;
            state_in       = S_SUM;
         end
         S_SUM: begin
            cmd.sum_load = 1'b1;
            state_in     = S_OUT;
         end
         S_OUT: begin
            if (out_free) begin
               cmd.out_load = 1'b1;
               state_in     = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (cmd.out_load) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

endmodule

// File: hw/rtl/jpsi_dp.sv
`timescale 1ns / 1ps
// Servo datapath: config registers, joint history RAM, serial divider,
// shared 33x16 multiplier, saturation and torque clamp. Depends on jpsi_pkg, jpsi_ram.
module jpsi_dp (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              csr_wr_en,
   input  logic [jpsi_pkg::CSR_IDX_W-1:0]    csr_index,
   input  logic [jpsi_pkg::CSR_DATA_W-1:0]   csr_wdata,
   input  jpsi_pkg::req_type                 req_payload,
   output jpsi_pkg::rsp_type                 rsp_payload,
   input  jpsi_pkg::dp_cmd_type              cmd,
   output jpsi_pkg::dp_status_type           status
);
   import jpsi_pkg::*;

   logic [INVP_W-1:0]      invp_ff;
   logic [STEPS_W-1:0]     interp_ff;
   logic [STEPS_W-1:0]     steps_left_ff, steps_left_in;
   logic [JOINTS-1:0]      seen_ff;
   req_type                in_ff;
   rsp_type                rsp_ff;
   logic signed [31:0]     qold_ff, rold_ff, r_ff, dq_ff, dr_ff;
   logic signed [31:0]     pterm_ff, dterm_ff, tau_ff;
   logic [MUL_A_W-1:0]     op_mag_ff, op_mag_in;
   logic                   op_neg_ff;
   logic [DIV_BITS-1:0]    div_quo_ff;
   logic [STEPS_W-1:0]     div_rem_ff;
   logic [DIV_CNT_W-1:0]   div_cnt_ff;
   logic [PROD_W-1:0]      prod_ff, prod_in;
   logic                   prod_neg_ff;
   logic [ACC_W-1:0]       acc_ff;
   logic                   acc_neg_ff;

   logic                   in_range;
   logic [JOINT_AW-1:0]    j_addr;
   logic [HIST_W-1:0]      ram_rdata;
   logic                   hist_hit;
   logic signed [32:0]     diff_w;
   logic [STEPS_W:0]       div_trial_w, div_sub_w;
   logic                   div_ge_w;
   logic [DIV_BITS-1:0]    quot_w;
   logic signed [33:0]     squot_w, ref_sum_w;
   logic [MUL_B_W-1:0]     mul_b_w;
   logic signed [31:0]     lim_w, nlim_w;
   logic                   clip_hi_w, clip_lo_w;

   assign in_range = (32'(in_ff.joint_index) < 32'(JOINTS));
   assign j_addr   = JOINT_AW'(in_ff.joint_index);
   assign hist_hit = in_range && seen_ff[j_addr];

   jpsi_ram #(
      .WIDTH (HIST_W),
      .DEPTH (JOINTS)
   ) u_hist (
      .clock   (clock),
      .wr_en   (cmd.out_load && in_range),
      .wr_addr (j_addr),
      .wr_data ({r_ff, in_ff.measured_angle}),
      .rd_en   (cmd.load),
      .rd_addr (JOINT_AW'(req_payload.joint_index)),
      .rd_data (ram_rdata)
   );

   // configuration
   always_ff @(posedge clock) begin
      if (reset) begin
         invp_ff   <= INVP_RESET;
         interp_ff <= STEPS_RESET;
      end else if (csr_wr_en) begin
         case (csr_index_type'(csr_index))
            CSR_INVERSE_PERIOD: invp_ff   <= csr_wdata[INVP_W-1:0];
            CSR_INTERP_STEPS:   interp_ff <= csr_wdata[STEPS_W-1:0];
            default: ;
         endcase
      end
   end

   // shared step counter and first-sample flags
   always_comb begin
      steps_left_in = steps_left_ff;
      if (cmd.load && req_payload.new_reference && (req_payload.joint_index == '0)) begin
         steps_left_in = interp_ff;
      end else if (cmd.out_load && in_ff.last_joint && (steps_left_ff != '0)) begin
         steps_left_in = steps_left_ff - STEPS_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         steps_left_ff <= STEPS_RESET;
         seen_ff       <= '0;
      end else begin
         steps_left_ff <= steps_left_in;
         if (cmd.out_load && in_range) begin
            seen_ff[j_addr] <= 1'b1;
         end
      end
   end

   // operand difference and magnitude
   always_comb begin
      case (cmd.op_sel)
         OP_GAP:  diff_w = 33'(in_ff.target_angle) - 33'(rold_ff);
         OP_DQ:   diff_w = 33'(in_ff.measured_angle) - 33'(qold_ff);
         OP_DR:   diff_w = 33'(r_ff) - 33'(rold_ff);
         OP_PE:   diff_w = 33'(r_ff) - 33'(in_ff.measured_angle);
         OP_DE:   diff_w = 33'(dr_ff) - 33'(dq_ff);
         default: diff_w = '0;
      endcase
      op_mag_in = diff_w[32] ? $unsigned(-diff_w) : $unsigned(diff_w);
   end

   // restoring divider, one quotient bit per cycle
   assign div_trial_w     = {div_rem_ff, div_quo_ff[DIV_BITS-1]};
   assign div_ge_w        = (div_trial_w >= {1'b0, steps_left_ff});
   assign div_sub_w       = div_trial_w - {1'b0, steps_left_ff};
   assign status.div_last = (div_cnt_ff == DIV_CNT_W'(1));

   assign quot_w    = (steps_left_ff == '0) ? '0 : div_quo_ff;
   assign squot_w   = op_neg_ff ? -$signed({1'b0, quot_w}) : $signed({1'b0, quot_w});
   assign ref_sum_w = 34'(rold_ff) + squot_w;

   always_comb begin
      case (cmd.gain_sel)
         GS_IP:   mul_b_w = invp_ff;
         GS_P_LO: mul_b_w = in_ff.p_gain[15:0];
         GS_P_HI: mul_b_w = {1'b0, in_ff.p_gain[30:16]};
         GS_D_LO: mul_b_w = in_ff.d_gain[15:0];
         GS_D_HI: mul_b_w = {1'b0, in_ff.d_gain[30:16]};
         default: mul_b_w = '0;
      endcase
      prod_in = PROD_W'(op_mag_ff) * PROD_W'(mul_b_w);
   end

   assign lim_w     = $signed({1'b0, in_ff.torque_limit});
   assign nlim_w    = -lim_w;
   assign clip_hi_w = (tau_ff > lim_w);
   assign clip_lo_w = (tau_ff < nlim_w);

   always_ff @(posedge clock) begin
      if (cmd.load) begin
         in_ff <= req_payload;
      end
      if (cmd.hist_load) begin
         qold_ff <= hist_hit ? $signed(ram_rdata[31:0])  : in_ff.measured_angle;
         rold_ff <= hist_hit ? $signed(ram_rdata[63:32]) : in_ff.measured_angle;
      end
      if (cmd.op_load) begin
         op_mag_ff <= op_mag_in;
         op_neg_ff <= diff_w[32];
      end
      if (cmd.div_start) begin
         div_quo_ff <= op_mag_ff;
         div_rem_ff <= '0;
         div_cnt_ff <= DIV_CNT_W'(DIV_BITS);
      end else if (cmd.div_step) begin
         div_quo_ff <= {div_quo_ff[DIV_BITS-2:0], div_ge_w};
         div_rem_ff <= div_ge_w ? div_sub_w[STEPS_W-1:0] : div_trial_w[STEPS_W-1:0];
         div_cnt_ff <= div_cnt_ff - DIV_CNT_W'(1);
      end
      if (cmd.ref_load) begin
         r_ff <= sat_wide(ref_sum_w);
      end
      if (cmd.mul) begin
         prod_ff     <= prod_in;
         prod_neg_ff <= op_neg_ff;
      end
      if (cmd.dq_load) begin
         dq_ff <= sat_mag(ACC_W'(prod_ff), prod_neg_ff);
      end
      if (cmd.dr_load) begin
         dr_ff <= sat_mag(ACC_W'(prod_ff), prod_neg_ff);
      end
      if (cmd.acc_set) begin
         acc_ff     <= ACC_W'(prod_ff >> 16);
         acc_neg_ff <= prod_neg_ff;
      end else if (cmd.acc_add) begin
         acc_ff <= acc_ff + ACC_W'(prod_ff);
      end
      if (cmd.pterm_load) begin
         pterm_ff <= sat_mag(acc_ff, acc_neg_ff);
      end
      if (cmd.dterm_load) begin
         dterm_ff <= sat_mag(acc_ff, acc_neg_ff);
      end
      if (cmd.sum_load) begin
         tau_ff <= in_ff.torque_mode ? in_ff.reference_torque
                                     : sat_wide(34'(pterm_ff) + 34'(dterm_ff));
      end
      if (cmd.out_load) begin
         rsp_ff.out_joint    <= in_ff.joint_index;
         rsp_ff.drive_torque <= clip_hi_w ? lim_w : (clip_lo_w ? nlim_w : tau_ff);
         rsp_ff.clamped      <= clip_hi_w || clip_lo_w;
      end
   end

   assign rsp_payload = rsp_ff;

endmodule

// File: hw/rtl/joint_pd_servo_interpolated.sv
`timescale 1ns / 1ps
// Multi-joint PD servo with linear reference interpolation and torque clamp.
// One transaction at a time: a new request is taken only in idle, after the previous result
// has been loaded into the output register, which waits while a response is pending; the pace
// is set by the serial interpolation divider and the six passes through the shared 33x16 multiplier.
// Reset: synchronous, clears step counter to one, first-sample flags, config to defaults.
module joint_pd_servo_interpolated (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            req_valid,
   output logic                            req_ready,
   input  jpsi_pkg::req_type               req_payload,
   output logic                            rsp_valid,
   input  logic                            rsp_ready,
   output jpsi_pkg::rsp_type               rsp_payload,
   input  logic                            csr_wr_en,
   input  logic [jpsi_pkg::CSR_IDX_W-1:0]  csr_index,
   input  logic [jpsi_pkg::CSR_DATA_W-1:0] csr_wdata
);
   import jpsi_pkg::*;

   dp_cmd_type    cmd;
   dp_status_type status;

   jpsi_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .cmd       (cmd),
      .status    (status)
   );

   jpsi_dp u_dp (
      .clock       (clock),
      .reset       (reset),
      .csr_wr_en   (csr_wr_en),
      .csr_index   (csr_index),
      .csr_wdata   (csr_wdata),
      .req_payload (req_payload),
      .rsp_payload (rsp_payload),
      .cmd         (cmd),
      .status      (status)
   );

endmodule

// File: verif/jpsi_servo_checker.sv
`timescale 1ns / 1ps
// Checker for the interpolated joint PD servo: predicts every response from a private copy of
// the servo state and register settings and compares responses in order. Depends on jpsi_pkg.
module jpsi_servo_checker (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            req_valid,
   input  logic                            req_ready,
   input  jpsi_pkg::req_type               req_payload,
   input  logic                            rsp_valid,
   input  logic                            rsp_ready,
   input  jpsi_pkg::rsp_type               rsp_payload,
   input  logic                            csr_wr_en,
   input  logic [jpsi_pkg::CSR_IDX_W-1:0]  csr_index,
   input  logic [jpsi_pkg::CSR_DATA_W-1:0] csr_wdata,
   output int                              error_count,
   output int                              outstanding,
   output int                              response_count,
   output int                              clamp_count
);
   import jpsi_pkg::*;

   localparam longint MAX32 = 64'sh0000_0000_7FFF_FFFF;
   localparam longint MIN32 = -64'sh0000_0000_8000_0000;

   logic [INVP_W-1:0]  rate_hz;
   logic [STEPS_W-1:0] interp_len;
   logic [STEPS_W-1:0] steps_remaining;
   logic signed [31:0] last_angle [JOINTS];
   logic signed [31:0] last_ref [JOINTS];
   logic               joint_started [JOINTS];
   rsp_type            torque_queue [$];
   int                 errors;
   int                 responses;
   int                 clamps;

   function automatic longint clip32(input longint v);
      if (v > MAX32) return MAX32;
      if (v < MIN32) return MIN32;
      return v;
   endfunction

   // (a * g) >> 16 on the magnitude, truncation toward zero, then saturate
   function automatic longint gain_scale(input longint a, input logic [30:0] g);
      longint unsigned mag;
      longint unsigned prod;
      mag = (a < 0) ? -a : a;
      prod = (mag * 64'(g)) >> 16;
      if (prod > 64'h8000_0000) prod = 64'h8000_0000;
      return clip32((a < 0) ? -longint'(prod) : longint'(prod));
   endfunction

   function automatic rsp_type servo_predict(input req_type t);
      int unsigned j;
      longint q, tgt, q_prev, r_prev, r, dq, dr, tau, lim;
      rsp_type res;
      j = 32'(t.joint_index);
      q = longint'($signed(t.measured_angle));
      tgt = longint'($signed(t.target_angle));
      lim = longint'(t.torque_limit);
      if (t.new_reference && j == 0) steps_remaining = interp_len;
      if (!joint_started[j]) begin
         last_angle[j] = t.measured_angle;
         last_ref[j] = t.measured_angle;
         joint_started[j] = 1'b1;
      end
      q_prev = longint'(last_angle[j]);
      r_prev = longint'(last_ref[j]);
      if (steps_remaining != 0) begin
         r = clip32(r_prev + (tgt - r_prev) / longint'(steps_remaining));
      end else begin
         r = r_prev;
      end
      dq = clip32((q - q_prev) * longint'(rate_hz));
      dr = clip32((r - r_prev) * longint'(rate_hz));
      last_angle[j] = q[31:0];
      last_ref[j] = r[31:0];
      if (t.torque_mode) begin
         tau = longint'($signed(t.reference_torque));
      end else begin
         tau = clip32(gain_scale(r - q, t.p_gain) + gain_scale(dr - dq, t.d_gain));
      end
      res.out_joint = t.joint_index;
      res.clamped = 1'b0;
      if (tau > lim) begin
         tau = lim;
         res.clamped = 1'b1;
      end else if (tau < -lim) begin
         tau = -lim;
         res.clamped = 1'b1;
      end
      res.drive_torque = tau[31:0];
      if (t.last_joint && steps_remaining != 0) steps_remaining = steps_remaining - 1'b1;
      return res;
   endfunction

   always @(posedge clock) begin : monitor
      rsp_type want;
      if (reset) begin
         rate_hz = INVP_RESET;
         interp_len = STEPS_RESET;
         steps_remaining = STEPS_RESET;
         for (int k = 0; k < JOINTS; k++) joint_started[k] = 1'b0;
         torque_queue.delete();
         errors = 0;
         responses = 0;
         clamps = 0;
      end else begin
         if (csr_wr_en) begin
            case (csr_index)
               CSR_INVERSE_PERIOD: rate_hz = csr_wdata[INVP_W-1:0];
               CSR_INTERP_STEPS:   interp_len = csr_wdata[STEPS_W-1:0];
               default: ;
            endcase
         end
         if (rsp_valid && rsp_ready) begin
            responses++;
            if (rsp_payload.clamped) clamps++;
            if (torque_queue.size() == 0) begin
               if (errors < 10) begin
                  $display("[%0t] unexpected response: joint %0d torque %0d clamp %0b",
                           $realtime, rsp_payload.out_joint, rsp_payload.drive_torque,
                           rsp_payload.clamped);
               end
               errors++;
            end else begin
               want = torque_queue.pop_front();
               if (want.out_joint !== rsp_payload.out_joint ||
                   want.drive_torque !== rsp_payload.drive_torque ||
                   want.clamped !== rsp_payload.clamped) begin
                  if (errors < 10) begin
                     $display("[%0t] mismatch exp/got: joint %0d/%0d torque %0d/%0d clamp %0b/%0b",
                              $realtime, want.out_joint, rsp_payload.out_joint,
                              want.drive_torque, rsp_payload.drive_torque,
                              want.clamped, rsp_payload.clamped);
                  end
                  errors++;
               end
            end
         end
         if (req_valid && req_ready) torque_queue.push_back(servo_predict(req_payload));
      end
      error_count <= errors;
      outstanding <= torque_queue.size();
      response_count <= responses;
      clamp_count <= clamps;
   end

endmodule

// File: verif/tb_joint_pd_servo_interpolated.sv
`timescale 1ns / 1ps
// Top of the joint PD servo testbench: clock, reset, register writes, joint sample stimulus
// and response back-pressure, plus the verdict. Depends on jpsi_pkg, the DUT and the checker.
module tb_joint_pd_servo_interpolated;
   import jpsi_pkg::*;

   localparam int            RANDOM_ITEMS = 1430;
   localparam logic [31:0]   S_MAX = 32'h7FFF_FFFF;
   localparam logic [31:0]   S_MIN = 32'h8000_0000;
   localparam logic [30:0]   G_MAX = 31'h7FFF_FFFF;

   logic                  clock = 1'b0;
   logic                  reset = 1'b1;
   logic                  req_valid = 1'b0;
   logic                  req_ready;
   req_type               req_payload = '0;
   logic                  rsp_valid;
   logic                  rsp_ready = 1'b0;
   rsp_type               rsp_payload;
   logic                  csr_wr_en = 1'b0;
   logic [CSR_IDX_W-1:0]  csr_index = '0;
   logic [CSR_DATA_W-1:0] csr_wdata = '0;

   int error_count, outstanding, response_count, clamp_count;
   int items_sent = 0;
   int settings_used = 1;
   int send_quiet_left = 0;
   int hold_off_cycles = 0;
   logic signed [31:0] goal [JOINTS];

   always #6 clock = ~clock;

   joint_pd_servo_interpolated DUT (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_ready   (req_ready),
      .req_payload (req_payload),
      .rsp_valid   (rsp_valid),
      .rsp_ready   (rsp_ready),
      .rsp_payload (rsp_payload),
      .csr_wr_en   (csr_wr_en),
      .csr_index   (csr_index),
      .csr_wdata   (csr_wdata)
   );

   jpsi_servo_checker checker_i (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_ready      (req_ready),
      .req_payload    (req_payload),
      .rsp_valid      (rsp_valid),
      .rsp_ready      (rsp_ready),
      .rsp_payload    (rsp_payload),
      .csr_wr_en      (csr_wr_en),
      .csr_index      (csr_index),
      .csr_wdata      (csr_wdata),
      .error_count    (error_count),
      .outstanding    (outstanding),
      .response_count (response_count),
      .clamp_count    (clamp_count)
   );

   function automatic logic signed [31:0] rand_angle();
      case ($urandom_range(0, 15))
         0:          return S_MAX;
         1:          return S_MIN;
         2, 3, 4, 5: return $urandom();
         6, 7, 8:    return 32'(int'($urandom_range(0, 33554431)) - 16777216);
         default:    return 32'(int'($urandom_range(0, 2097151)) - 1048576);
      endcase
   endfunction

   function automatic logic [30:0] rand_gain();
      case ($urandom_range(0, 15))
         0:       return '0;
         1:       return G_MAX;
         2, 3, 4: return 31'($urandom());
         default: return 31'($urandom_range(0, 4194303));
      endcase
   endfunction

   function automatic logic [30:0] rand_limit();
      case ($urandom_range(0, 15))
         0:       return '0;
         1:       return G_MAX;
         2, 3, 4: return 31'($urandom());
         default: return 31'($urandom_range(0, 16777215));
      endcase
   endfunction

   function automatic req_type joint_sample(input int joint, input bit last, input bit fresh,
                                            input logic [31:0] meas, input logic [31:0] tgt,
                                            input logic [31:0] tq, input bit mode,
                                            input logic [30:0] pg, input logic [30:0] dg,
                                            input logic [30:0] lim);
      req_type it;
      it.joint_index = 5'(joint);
      it.last_joint = last;
      it.new_reference = fresh;
      it.measured_angle = meas;
      it.target_angle = tgt;
      it.reference_torque = tq;
      it.torque_mode = mode;
      it.p_gain = pg;
      it.d_gain = dg;
      it.torque_limit = lim;
      return it;
   endfunction

   task automatic send_item(input req_type item);
      int gap;
      if (send_quiet_left > 0) begin
         gap = 0;
         send_quiet_left--;
      end else begin
         gap = $urandom_range(0, 14);
         if ($urandom_range(0, 49) == 0) send_quiet_left = $urandom_range(10, 40);
      end
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_payload <= item;
      do @(posedge clock); while (!req_ready);
      items_sent++;
   endtask

   // sender pause: let every outstanding transaction come back
   task automatic wait_idle();
      req_valid <= 1'b0;
      @(posedge clock);
      while (outstanding != 0) @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   task automatic write_regs(input logic [CSR_DATA_W-1:0] rate,
                             input logic [CSR_DATA_W-1:0] steps);
      csr_wr_en <= 1'b1;
      csr_index <= CSR_INVERSE_PERIOD;
      csr_wdata <= rate;
      @(posedge clock);
      csr_index <= CSR_INTERP_STEPS;
      csr_wdata <= steps;
      @(posedge clock);
      csr_wr_en <= 1'b0;
   endtask

   // one control period: joints 0..n-1, last_joint on the final one
   task automatic run_period();
      int n;
      bit fresh;
      req_type it;
      case ($urandom_range(0, 7))
         0:       n = JOINTS;
         1:       n = $urandom_range(7, JOINTS - 1);
         default: n = $urandom_range(1, 6);
      endcase
      fresh = ($urandom_range(0, 2) == 0);
      for (int j = 0; j < n; j++) begin
         if (fresh) goal[j] = rand_angle();
         it.joint_index = 5'(j);
         it.last_joint = (j == n - 1);
         it.new_reference = fresh && (j == 0);
         it.target_angle = goal[j];
         if ($urandom_range(0, 7) == 0) begin
            it.measured_angle = rand_angle();
         end else begin
            it.measured_angle = goal[j] + 32'(int'($urandom_range(0, 65535)) - 32768);
         end
         it.reference_torque = rand_angle();
         it.torque_mode = ($urandom_range(0, 5) == 0);
         it.p_gain = rand_gain();
         it.d_gain = rand_gain();
         it.torque_limit = rand_limit();
         send_item(it);
      end
   endtask

   task automatic send_noise();
      logic [223:0] raw;
      req_type it;
      raw = {$urandom(), $urandom(), $urandom(), $urandom(), $urandom(), $urandom(),
             $urandom()};
      it = raw[$bits(req_type)-1:0];
      send_item(it);
   endtask

   initial begin : rsp_side
      int stall;
      int quiet_left;
      quiet_left = 0;
      forever begin
         if (hold_off_cycles > 0) begin
            stall = hold_off_cycles;
            hold_off_cycles = 0;
         end else if (quiet_left > 0) begin
            stall = 0;
            quiet_left--;
         end else begin
            stall = $urandom_range(0, 14);
            if ($urandom_range(0, 49) == 0) quiet_left = $urandom_range(10, 40);
         end
         if (stall > 0) begin
            rsp_ready <= 1'b0;
            repeat (stall) @(posedge clock);
         end
         rsp_ready <= 1'b1;
         do @(posedge clock); while (!rsp_valid);
      end
   end

   initial begin : stimulus
      int phase_end;
      bit hold_done;
      logic [CSR_DATA_W-1:0] rate, steps;
      hold_done = 1'b0;
      for (int k = 0; k < JOINTS; k++) goal[k] = rand_angle();
      repeat (10) @(posedge clock);
      reset <= 1'b0;

      // reset settings: rate 200, one interpolation step
      send_item(joint_sample(0, 0, 1, '0, '0, '0, 0, '0, '0, '0));
      send_item(joint_sample(1, 0, 0, 32'h0001_0000, 32'h0002_0000, '0, 0,
                             31'h0001_0000, 31'h0000_0148, G_MAX));
      send_item(joint_sample(1, 0, 0, 32'h0001_8000, 32'h0003_0000, '0, 0,
                             31'h0001_0000, 31'h0000_0148, G_MAX));
      send_item(joint_sample(31, 0, 0, S_MAX, S_MIN, '0, 0, G_MAX, G_MAX, G_MAX));
      send_item(joint_sample(31, 0, 0, S_MIN, S_MAX, '0, 0, G_MAX, G_MAX, '0));
      send_item(joint_sample(2, 0, 0, '0, '0, S_MIN, 1, '0, '0, G_MAX));
      send_item(joint_sample(3, 0, 0, '0, '0, S_MAX, 1, '0, '0, G_MAX));
      send_item(joint_sample(4, 0, 0, '0, '0, 32'hFFFB_0000, 1, '0, '0, 31'h0002_0000));
      send_item(joint_sample(5, 1, 1, 32'h0000_4000, 32'h0005_0000, '0, 0,
                             31'h0004_0000, 31'h0000_1000, 31'h0010_0000));
      send_item(joint_sample(0, 0, 0, 32'h0000_1000, 32'h0009_0000, '0, 0,
                             31'h0002_0000, 31'h0000_0800, G_MAX));
      send_item(joint_sample(1, 1, 0, 32'hFFFF_0000, 32'h0004_0000, '0, 0,
                             31'h0002_0000, 31'h0000_0800, G_MAX));

      wait_idle();
      write_regs(16'd0, 16'd0);
      settings_used++;
      send_item(joint_sample(0, 0, 1, 32'h0003_0000, 32'hFFF0_0000, '0, 0,
                             31'h0001_0000, 31'h0001_0000, G_MAX));
      send_item(joint_sample(6, 1, 0, 32'h0001_0000, 32'h0002_0000, '0, 0,
                             31'h0001_0000, 31'h0001_0000, G_MAX));

      wait_idle();
      write_regs(16'hFFFF, 16'd1024);
      settings_used++;
      send_item(joint_sample(0, 0, 1, '0, 32'h0064_0000, '0, 0,
                             31'h000A_0000, 31'h0001_0000, G_MAX));
      send_item(joint_sample(1, 1, 0, 32'h0000_0100, 32'h0010_0000, '0, 0,
                             31'h000A_0000, 31'h0001_0000, 31'h0100_0000));
      send_item(joint_sample(0, 0, 0, 32'h0000_0200, 32'h0064_0000, '0, 0,
                             31'h000A_0000, 31'h0001_0000, G_MAX));
      send_item(joint_sample(7, 1, 0, $urandom(), $urandom(), $urandom(), 0,
                             G_MAX, G_MAX, 31'h0000_0001));

      wait_idle();
      write_regs(16'd200, 16'd3);
      settings_used++;
      send_item(joint_sample(0, 0, 1, '0, 32'hFFF9_0000, '0, 0,
                             31'h0003_0000, 31'h0000_0400, G_MAX));
      send_item(joint_sample(31, 1, 0, 32'h0000_8000, 32'h0001_0000, '0, 0,
                             31'h0003_0000, 31'h0000_0400, G_MAX));
      for (int k = 0; k < 4; k++) begin
         send_item(joint_sample(0, 1, 0, 32'hFFFF_C000, 32'hFFF9_0000, '0, 0,
                                31'h0003_0000, 31'h0000_0400, G_MAX));
      end

      for (int phase = 0; phase < 8; phase++) begin
         case (phase)
            0:       begin rate = 16'd1;     steps = 16'd1;    end
            1:       begin rate = 16'hFFFF;  steps = 16'd1024; end
            2:       begin rate = 16'd200;   steps = 16'd4;    end
            3: begin
               rate  = 16'($urandom_range(1, 65535));
               steps = 16'($urandom_range(1, 16));
            end
            4:       begin rate = 16'd0;     steps = 16'd0;    end
            5: begin
               rate  = 16'd1000;
               steps = 16'($urandom_range(1, 1024));
            end
            6:       begin rate = 16'hFFFF;  steps = 16'd2;    end
            default: begin
               rate  = 16'($urandom_range(1, 65535));
               steps = 16'($urandom_range(1, 1024));
            end
         endcase
         wait_idle();
         write_regs(rate, steps);
         settings_used++;
         phase_end = 23 + (RANDOM_ITEMS * (phase + 1)) / 8;
         while (items_sent < phase_end) begin
            if (!hold_done && phase == 2) begin
               hold_off_cycles = 600;
               hold_done = 1'b1;
            end
            if ($urandom_range(0, 6) == 0) begin
               repeat ($urandom_range(1, 3)) send_noise();
            end else begin
               run_period();
            end
         end
      end

      req_valid <= 1'b0;
      @(posedge clock);
      while (outstanding != 0) @(posedge clock);
      repeat (60) @(posedge clock);
      $display("Covered %0d joint samples over %0d register settings, rates 0 to 65535",
               items_sent, settings_used);
      $display("Checked %0d responses, %0d of them at the torque limit",
               response_count, clamp_count);
      if (error_count == 0 && outstanding == 0) begin
         $display("[joint_pd_servo_interpolated] OK");
      end else begin
         $display("[joint_pd_servo_interpolated] ERROR");
      end
      $finish;
   end

   initial begin : watchdog
      #8_400_000;
      $display("[joint_pd_servo_interpolated] ERROR");
      $finish;
   end

endmodule
